FILE: src/two_tier_event_log_buffer_core_defines.svh
// assertion macros shared by the event log blocks
// each macro expects clk and rst_n in the enclosing scope
`ifndef TWO_TIER_EVENT_LOG_BUFFER_CORE_DEFINES_SVH
`define TWO_TIER_EVENT_LOG_BUFFER_CORE_DEFINES_SVH

// a condition that must never be seen at a clock edge
`define TTEL_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define TTEL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTEL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ttel_pkg.sv
`default_nettype none

package ttel_pkg;

    // request opcodes
    localparam logic [1:0] OP_LOG   = 2'd0;
    localparam logic [1:0] OP_DRAIN = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] TIER_CRITICAL = 3'd0;

    // default sizes
    localparam int CRIT_DEPTH_DEF = 16;
    localparam int GEN_DEPTH_DEF  = 64;
    localparam int MAX_DRAIN_DEF  = 16;

    // one stored log entry
    typedef struct packed {
        logic [2:0]  tier;
        logic [15:0] event_id;
        logic [31:0] time_ms;
        logic [31:0] payload;
    } entry_t;

    // per-cycle commands to a ring
    typedef struct packed {
        logic wr;
        logic rd;
        logic clr;
    } ring_ctl_t;

endpackage

`default_nettype wire

FILE: src/ttel_if.sv
`default_nettype none

// request channel
interface ttel_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [2:0]  tier;
    logic [15:0] event_id;
    logic [31:0] payload;
    logic [31:0] time_ms;
    logic [4:0]  drain_limit;

    modport source (output valid, output opcode, output tier, output event_id,
                    output payload, output time_ms, output drain_limit, input ready);
    modport sink (input valid, input opcode, input tier, input event_id,
                  input payload, input time_ms, input drain_limit, output ready);
endinterface

// result channel
interface ttel_rsp_if;
    logic        valid;
    logic        ready;
    logic        entry_valid;
    logic        last_entry;
    logic [2:0]  entry_tier;
    logic [15:0] entry_id;
    logic [31:0] entry_payload;
    logic [31:0] entry_time;
    logic        critical_overflowed;

    modport source (output valid, output entry_valid, output last_entry,
                    output entry_tier, output entry_id, output entry_payload,
                    output entry_time, output critical_overflowed, input ready);
    modport sink (input valid, input entry_valid, input last_entry,
                  input entry_tier, input entry_id, input entry_payload,
                  input entry_time, input critical_overflowed, output ready);
endinterface

`default_nettype wire

FILE: src/ttel_ring.sv
`default_nettype none

`include "two_tier_event_log_buffer_core_defines.svh"

module ttel_ring #(
    parameter int DEPTH     = ttel_pkg::CRIT_DEPTH_DEF,
    parameter bit OVERWRITE = 1'b0
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  ttel_pkg::ring_ctl_t          ctl,
    input  ttel_pkg::entry_t             wr_data,
    output ttel_pkg::entry_t             rd_data,
    output logic [$clog2(DEPTH+1)-1:0]   fill,
    output logic                         full
);

    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    ttel_pkg::entry_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          ovr;

    assign full = (fill_reg == FW'(DEPTH));
    assign fill = fill_reg;
    // a write into a full overwrite ring drops the oldest entry
    assign ovr  = OVERWRITE && ctl.wr && full;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (ctl.clr)
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            fill_next   = '0;
        end
        else
        begin
            if (ctl.wr)
            begin
                wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (ctl.rd || ovr)
            begin
                rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (ctl.wr && !ovr)
            begin
                fill_next = fill_reg + FW'(1);
            end
            else if (ctl.rd)
            begin
                fill_next = fill_reg - FW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage, read data held until the next read
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (ctl.rd)
        begin
            rd_data <= mem[rd_ptr_reg];
        end
    end

    `TTEL_ASSERT_NEVER(a_fill_bound, fill_reg > FW'(DEPTH), "ring fill above depth")
    `TTEL_ASSERT_IMPLIES(a_rd_nonempty, ctl.rd, fill_reg != '0, "read from empty ring")
    `TTEL_ASSERT_IMPLIES(a_no_drop_write, ctl.wr && full, OVERWRITE, "write into full ring")

endmodule

`default_nettype wire

FILE: src/two_tier_event_log_buffer_core.sv
`default_nettype none

// channel | role | carries
// req     | sink   | log, drain and clear requests
// rsp     | source | drained entries, one per result on rsp
//
// log and clear requests take effect when accepted; a log may follow every cycle while req.ready is high
// a drain reads each entry through the ring memory port, then passes it on from the
// output register; with rsp.ready high the entries leave at one entry per cycle
// an empty drain, or one with a limit of zero, gives one result with entry_valid low
// while a drain is running req.ready is low; rsp stalls hold the ring reads
// rst_n clears pointers, fill counts, overflow flag and control; ring contents stay

`include "two_tier_event_log_buffer_core_defines.svh"

module two_tier_event_log_buffer_core #(
    parameter int CRIT_DEPTH = ttel_pkg::CRIT_DEPTH_DEF,
    parameter int GEN_DEPTH  = ttel_pkg::GEN_DEPTH_DEF,
    parameter int MAX_DRAIN  = ttel_pkg::MAX_DRAIN_DEF
) (
    input  wire       clk,
    input  wire       rst_n,
    ttel_req_if.sink  req,
    ttel_rsp_if.source rsp
);

    localparam int CFW = $clog2(CRIT_DEPTH + 1);
    localparam int GFW = $clog2(GEN_DEPTH + 1);
    localparam int LW  = $clog2(MAX_DRAIN + 1);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_FLUSH} state_t;

    state_t              state_reg;
    logic [LW-1:0]       lim_reg;
    logic [LW-1:0]       cnt_reg;
    logic                pend_reg;
    logic                pend_crit_reg;
    logic                pend_last_reg;
    logic                flag_reg;
    logic                out_valid_reg;
    logic                out_evalid_reg;
    logic                out_last_reg;
    logic                out_ovf_reg;
    ttel_pkg::entry_t    out_entry_reg;

    ttel_pkg::ring_ctl_t crit_ctl, gen_ctl;
    ttel_pkg::entry_t    crit_rdata, gen_rdata, wr_entry, pend_entry;
    logic [CFW-1:0]      crit_fill;
    logic [GFW-1:0]      gen_fill;
    logic                crit_full, gen_full;

    logic                accept, is_log, is_crit, is_drain, is_clear;
    logic                slot_free, load_pend, load_empty, empty_case;
    logic                issue, issue_last, both_empty, one_left;
    logic [LW-1:0]       lim_sat;

    // request decode
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign is_log    = accept && (req.opcode == ttel_pkg::OP_LOG);
    assign is_drain  = accept && (req.opcode == ttel_pkg::OP_DRAIN);
    assign is_clear  = accept && (req.opcode == ttel_pkg::OP_CLEAR);
    assign is_crit   = (req.tier == ttel_pkg::TIER_CRITICAL);

    assign wr_entry.tier     = req.tier;
    assign wr_entry.event_id = req.event_id;
    assign wr_entry.time_ms  = req.time_ms;
    assign wr_entry.payload  = req.payload;

    assign lim_sat = ({27'd0, req.drain_limit} > 32'(MAX_DRAIN)) ? LW'(MAX_DRAIN)
                                                                 : LW'(req.drain_limit);

    // drain read scheduling
    assign both_empty = (crit_fill == '0) && (gen_fill == '0);
    assign one_left   = ((crit_fill == CFW'(1)) && (gen_fill == '0)) ||
                        ((crit_fill == '0) && (gen_fill == GFW'(1)));
    assign empty_case = (lim_reg == '0) || both_empty;
    assign slot_free  = !out_valid_reg || rsp.ready;
    assign load_pend  = pend_reg && slot_free;
    assign load_empty = (state_reg == S_ISSUE) && empty_case && slot_free;
    assign issue      = (state_reg == S_ISSUE) && !empty_case && (!pend_reg || load_pend);
    assign issue_last = ((cnt_reg + LW'(1)) == lim_reg) || one_left;

    // ring commands
    always_comb
    begin
        crit_ctl.clr = is_clear;
        gen_ctl.clr  = is_clear;
        crit_ctl.wr  = is_log && is_crit && !crit_full;
        gen_ctl.wr   = is_log && !is_crit;
        crit_ctl.rd  = issue && (crit_fill != '0);
        gen_ctl.rd   = issue && (crit_fill == '0);
    end

    ttel_ring #(.DEPTH(CRIT_DEPTH), .OVERWRITE(1'b0)) u_crit_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (crit_ctl),
        .wr_data (wr_entry),
        .rd_data (crit_rdata),
        .fill    (crit_fill),
        .full    (crit_full)
    );

    ttel_ring #(.DEPTH(GEN_DEPTH), .OVERWRITE(1'b1)) u_gen_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (gen_ctl),
        .wr_data (wr_entry),
        .rd_data (gen_rdata),
        .fill    (gen_fill),
        .full    (gen_full)
    );

    assign pend_entry = pend_crit_reg ? crit_rdata : gen_rdata;

    // state, drain control and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            lim_reg        <= '0;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_crit_reg  <= 1'b0;
            pend_last_reg  <= 1'b0;
            flag_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_evalid_reg <= 1'b0;
            out_last_reg   <= 1'b0;
            out_ovf_reg    <= 1'b0;
            out_entry_reg  <= '0;
        end
        else
        begin
            // overflow flag
            if (is_clear)
            begin
                flag_reg <= 1'b0;
            end
            else if (is_log && is_crit && crit_full)
            begin
                flag_reg <= 1'b1;
            end

            // output register, flag captured with the entry
            if (load_pend)
            begin
                out_valid_reg  <= 1'b1;
                out_evalid_reg <= 1'b1;
                out_last_reg   <= pend_last_reg;
                out_ovf_reg    <= flag_reg;
                out_entry_reg  <= pend_entry;
            end
            else if (load_empty)
            begin
                out_valid_reg  <= 1'b1;
                out_evalid_reg <= 1'b0;
                out_last_reg   <= 1'b1;
                out_ovf_reg    <= flag_reg;
                out_entry_reg  <= '0;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // read in flight
            if (issue)
            begin
                pend_reg      <= 1'b1;
                pend_crit_reg <= (crit_fill != '0);
                pend_last_reg <= issue_last;
            end
            else if (load_pend)
            begin
                pend_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (is_drain)
                    begin
                        lim_reg   <= lim_sat;
                        cnt_reg   <= '0;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    if (load_empty)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (issue)
                    begin
                        cnt_reg <= cnt_reg + LW'(1);
                        if (issue_last)
                        begin
                            state_reg <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH:
                begin
                    if (load_pend)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid               = out_valid_reg;
    assign rsp.entry_valid         = out_evalid_reg;
    assign rsp.last_entry          = out_last_reg;
    assign rsp.entry_tier          = out_entry_reg.tier;
    assign rsp.entry_id            = out_entry_reg.event_id;
    assign rsp.entry_payload       = out_entry_reg.payload;
    assign rsp.entry_time          = out_entry_reg.time_ms;
    assign rsp.critical_overflowed = out_ovf_reg;

    `TTEL_ASSERT_IMPLIES(a_idle_no_pend, state_reg == S_IDLE, !pend_reg, "read pending in idle")
    `TTEL_ASSERT_NEVER(a_one_ring_read, crit_ctl.rd && gen_ctl.rd, "both rings read at once")
    `TTEL_ASSERT_NEXT(a_last_ends_drain, (load_pend && pend_last_reg) || load_empty,
                      state_reg == S_IDLE, "drain not closed after last entry")
    `TTEL_ASSERT_NEVER(a_gen_full_unused, gen_full && (gen_fill != GFW'(GEN_DEPTH)),
                       "general ring full flag disagrees with fill")

endmodule

`default_nettype wire
